/* sv/fsd_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helpers for the 16-bit error-diffusion dither.
package fsd_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int NUM_CH     = 4;
	localparam int PIX_W      = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int LW_W       = 11;
	localparam int MW_BITS    = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W      = (MW_BITS > LW_W) ? MW_BITS : LW_W;

	// error line: one entry per column plus two tail entries, split over four banks
	localparam int LINE_DEPTH = MAX_WIDTH + 2;
	localparam int ENT_W      = $clog2(LINE_DEPTH);
	localparam int BANK_SEL_W = 2;
	localparam int NUM_BANKS  = 1 << BANK_SEL_W;
	localparam int BANK_DEPTH = (LINE_DEPTH + NUM_BANKS - 1) / NUM_BANKS;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int NUM_WR     = 3;

	// error widths: stored entry, right share, the two pending partial sums
	localparam int ERR_W      = 7;
	localparam int RIGHT_W    = 6;
	localparam int P0_W       = 6;
	localparam int P1_W       = 3;
	localparam int MUL_W      = ERR_W + 3;
	localparam int ENTRY_BITS = NUM_CH * ERR_W;

	localparam int APB_AW     = 4;
	localparam logic [1:0] REG_OUT_FMT       = 2'd0;
	localparam logic [1:0] REG_SWAP_RED_BLUE = 2'd1;
	localparam logic [1:0] REG_LINE_WIDTH    = 2'd2;
	localparam logic [LW_W-1:0] LW_RESET     = LW_W'(1024);

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;
	localparam logic [1:0] CH_ALPHA = 2'd3;

	typedef enum logic [1:0] {
		FMT_RGBA4444,
		FMT_RGBA5551,
		FMT_RGB555,
		FMT_RGB565
	} fmt_t;

	typedef logic [NUM_CH-1:0][PIX_W-1:0]   pix_t;
	typedef logic [NUM_CH-1:0][ERR_W-1:0]   line_entry_t;
	typedef logic [NUM_CH-1:0][RIGHT_W-1:0] right_err_t;
	typedef logic [NUM_CH-1:0][P0_W-1:0]    pend0_t;
	typedef logic [NUM_CH-1:0][P1_W-1:0]    pend1_t;

	typedef struct packed {
		right_err_t  right;
		pend0_t      pend0;
		pend1_t      pend1;
		line_entry_t above;
	} err_in_t;

	typedef struct packed {
		right_err_t  right;
		pend0_t      pend0;
		pend1_t      pend1;
		line_entry_t below;
	} err_upd_t;

	function automatic logic [ERR_W-1:0] drop_mask(fmt_t f, logic [1:0] ch);
		logic [ERR_W-1:0] m;
		m = '0;
		case (f)
			FMT_RGBA4444: m = ERR_W'('h0f);
			FMT_RGBA5551: m = (ch == CH_ALPHA) ? ERR_W'('h7f) : ERR_W'('h07);
			FMT_RGB555:   m = (ch == CH_ALPHA) ? ERR_W'('h00) : ERR_W'('h07);
			FMT_RGB565: begin
				if (ch == CH_ALPHA)
					m = ERR_W'('h00);
				else if (ch == CH_GREEN)
					m = ERR_W'('h03);
				else
					m = ERR_W'('h07);
			end
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [BANK_SEL_W-1:0] bank_sel(logic [ENT_W-1:0] k);
		return k[BANK_SEL_W-1:0];
	endfunction

	function automatic logic [BANK_AW-1:0] bank_row(logic [ENT_W-1:0] k);
		return BANK_AW'(k >> BANK_SEL_W);
	endfunction

endpackage

/* sv/fsd_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module fsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* sv/fsd_pixel.sv */
`timescale 1ns / 1ps
// Per-pixel datapath: error add, saturation, 16-bit packing and error shares.
module fsd_pixel (
	input  fsd_pkg::fmt_t    fmt,
	input  logic             swap_red_blue,
	input  fsd_pkg::pix_t    pix,
	input  fsd_pkg::err_in_t err_in,
	output logic [15:0]      pixel_word,
	output fsd_pkg::err_upd_t upd
);

	localparam int SUM_W = fsd_pkg::PIX_W + 1;

	logic [SUM_W-1:0]              sum [fsd_pkg::NUM_CH];
	logic [fsd_pkg::PIX_W-1:0]     val [fsd_pkg::NUM_CH];
	logic [fsd_pkg::ERR_W-1:0]     err [fsd_pkg::NUM_CH];
	logic [fsd_pkg::MUL_W-1:0]     e3  [fsd_pkg::NUM_CH];
	logic [fsd_pkg::MUL_W-1:0]     e5  [fsd_pkg::NUM_CH];
	logic [fsd_pkg::MUL_W-1:0]     e7  [fsd_pkg::NUM_CH];
	logic [fsd_pkg::PIX_W-1:0]     r, g, b, a;

	always_comb begin
		for (int ch = 0; ch < fsd_pkg::NUM_CH; ch++) begin
			sum[ch] = SUM_W'(pix[ch]) + SUM_W'(err_in.right[ch]) + SUM_W'(err_in.above[ch]);
			val[ch] = sum[ch][fsd_pkg::PIX_W] ? '1 : sum[ch][fsd_pkg::PIX_W-1:0];
			err[ch] = val[ch][fsd_pkg::ERR_W-1:0] & fsd_pkg::drop_mask(fmt, 2'(ch));
			e3[ch]  = fsd_pkg::MUL_W'(err[ch]) * fsd_pkg::MUL_W'(3);
			e5[ch]  = fsd_pkg::MUL_W'(err[ch]) * fsd_pkg::MUL_W'(5);
			e7[ch]  = fsd_pkg::MUL_W'(err[ch]) * fsd_pkg::MUL_W'(7);
			upd.right[ch] = fsd_pkg::RIGHT_W'(e7[ch] >> 4);
			upd.pend0[ch] = fsd_pkg::P0_W'(fsd_pkg::MUL_W'(err_in.pend1[ch]) + (e5[ch] >> 4));
			upd.pend1[ch] = fsd_pkg::P1_W'(err[ch] >> 4);
			upd.below[ch] = fsd_pkg::ERR_W'(fsd_pkg::MUL_W'(err_in.pend0[ch]) + (e3[ch] >> 4));
		end
	end

	assign r = val[fsd_pkg::CH_RED];
	assign g = val[fsd_pkg::CH_GREEN];
	assign b = val[fsd_pkg::CH_BLUE];
	assign a = val[fsd_pkg::CH_ALPHA];

	always_comb begin
		case (fmt)
			fsd_pkg::FMT_RGBA4444: begin
				if (swap_red_blue)
					pixel_word = {r[7:4], g[7:4], b[7:4], a[7:4]};
				else
					pixel_word = {b[7:4], g[7:4], r[7:4], a[7:4]};
			end
			fsd_pkg::FMT_RGBA5551: pixel_word = {b[7:3], g[7:3], r[7:3], a[7]};
			fsd_pkg::FMT_RGB555:   pixel_word = {1'b0, b[7:3], g[7:3], r[7:3]};
			fsd_pkg::FMT_RGB565: begin
				if (swap_red_blue)
					pixel_word = {b[7:3], g[7:2], r[7:3]};
				else
					pixel_word = {r[7:3], g[7:2], b[7:3]};
			end
			default: pixel_word = '0;
		endcase
	end

endmodule

/* sv/floyd_steinberg_dither_16bit.sv */
`timescale 1ns / 1ps
// Top level: Floyd-Steinberg dither from RGBA8888 to 16-bit pixel formats.
//
//  channel   dir  width  contents
//  s_axis    in   32+1   tdata: red, green, blue, alpha; tuser: start_of_frame
//  m_axis    out  16     tdata: pixel_word
//  apb       in   32     output format @0x0, swap_red_blue @0x4, line_width @0x8
//
// One pixel per clock sustained while m_axis does not stall; each pixel passes through
// the input register, then the output register. The error line lives in four RAM
// banks, one read and up to three writes (row end) per pixel, same-cycle hits bypassed.
// After reset a clearing pass zeroes all BANK_DEPTH (257) rows of the error line banks,
// s_axis_tready low meanwhile. An m_axis stall holds the output register and
// backs up into s_axis_tready once the input register is full.
module floyd_steinberg_dither_16bit (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fsd_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,

	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,   // red, green, blue, alpha
	input  logic                        s_axis_tuser,   // start_of_frame

	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [15:0]                 m_axis_tdata    // pixel_word
);

	localparam logic [fsd_pkg::BANK_AW-1:0] CLR_LAST = fsd_pkg::BANK_AW'(fsd_pkg::BANK_DEPTH - 1);

	// configuration
	fsd_pkg::fmt_t               out_fmt_q;
	logic                        swap_red_blue_q;
	logic [fsd_pkg::LW_W-1:0]    line_width_q;
	logic                        cfg_we;
	logic [1:0]                  reg_idx;

	// frame / row state
	logic [fsd_pkg::COL_W-1:0]   column_q;
	logic                        first_row_q;
	fsd_pkg::right_err_t         right_q;
	fsd_pkg::pend0_t             pend0_q;
	fsd_pkg::pend1_t             pend1_q;

	// clearing pass
	logic                        clr_active_q;
	logic [fsd_pkg::BANK_AW-1:0] clr_idx_q;

	// input side
	logic                        in_acc;
	logic                        sof_in;
	logic [fsd_pkg::COL_W-1:0]   col_in;
	logic                        fr_in;
	logic [fsd_pkg::CMP_W-1:0]   lw_ext;
	logic [fsd_pkg::CMP_W-1:0]   w_eff;
	logic                        row_end_in;
	logic [fsd_pkg::ENT_W-1:0]   rd_ent;
	logic [fsd_pkg::BANK_AW-1:0] rd_row;

	// stage 1
	logic                        valid_s1;
	fsd_pkg::pix_t               pix_s1;
	logic [fsd_pkg::COL_W-1:0]   col_s1;
	logic                        row_start_s1;
	logic                        first_row_s1;
	logic                        row_end_s1;
	logic [fsd_pkg::BANK_SEL_W-1:0] rd_bank_s1;
	logic                        byp_hit_s1;
	fsd_pkg::line_entry_t        byp_data_s1;
	logic                        adv;

	// stage 2 (output register)
	logic                        valid_s2;
	logic [15:0]                 word_s2;

	// datapath
	fsd_pkg::err_in_t            err_in;
	fsd_pkg::err_upd_t           upd;
	logic [15:0]                 word;

	// error line writes and banks
	logic [fsd_pkg::ENT_W-1:0]   wr_ent  [fsd_pkg::NUM_WR];
	logic                        wr_en   [fsd_pkg::NUM_WR];
	fsd_pkg::line_entry_t        wr_data [fsd_pkg::NUM_WR];
	logic                        byp_hit;
	fsd_pkg::line_entry_t        byp_data;
	logic                        bank_we    [fsd_pkg::NUM_BANKS];
	logic [fsd_pkg::BANK_AW-1:0] bank_waddr [fsd_pkg::NUM_BANKS];
	fsd_pkg::line_entry_t        bank_wdata [fsd_pkg::NUM_BANKS];
	fsd_pkg::line_entry_t        bank_rdata [fsd_pkg::NUM_BANKS];

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[fsd_pkg::APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_fmt_q       <= fsd_pkg::FMT_RGB565;
			swap_red_blue_q <= 1'b0;
			line_width_q    <= fsd_pkg::LW_RESET;
		end else if (cfg_we) begin
			case (reg_idx)
				fsd_pkg::REG_OUT_FMT:       out_fmt_q       <= fsd_pkg::fmt_t'(pwdata[1:0]);
				fsd_pkg::REG_SWAP_RED_BLUE: swap_red_blue_q <= pwdata[0];
				fsd_pkg::REG_LINE_WIDTH:    line_width_q    <= pwdata[fsd_pkg::LW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			fsd_pkg::REG_OUT_FMT:       prdata = 32'(out_fmt_q);
			fsd_pkg::REG_SWAP_RED_BLUE: prdata = 32'(swap_red_blue_q);
			fsd_pkg::REG_LINE_WIDTH:    prdata = 32'(line_width_q);
			default:                    prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	assign adv           = valid_s1 & (~valid_s2 | m_axis_tready);
	assign s_axis_tready = ~clr_active_q & (~valid_s1 | adv);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = word_s2;

	// ---------------- column tracking at input transfer ----------------
	assign sof_in = s_axis_tuser;
	assign col_in = sof_in ? '0 : column_q;
	assign fr_in  = sof_in | first_row_q;
	assign lw_ext = fsd_pkg::CMP_W'(line_width_q);

	always_comb begin
		if (lw_ext == '0)
			w_eff = fsd_pkg::CMP_W'(1);
		else if (lw_ext > fsd_pkg::CMP_W'(fsd_pkg::MAX_WIDTH))
			w_eff = fsd_pkg::CMP_W'(fsd_pkg::MAX_WIDTH);
		else
			w_eff = lw_ext;
	end

	assign row_end_in = (fsd_pkg::CMP_W'(col_in) + fsd_pkg::CMP_W'(1)) >= w_eff;
	assign rd_ent     = fsd_pkg::ENT_W'(col_in) + fsd_pkg::ENT_W'(1);
	assign rd_row     = fsd_pkg::bank_row(rd_ent);

	// ---------------- stage 1 datapath ----------------
	always_comb begin
		err_in.right = row_start_s1 ? '0 : right_q;
		err_in.pend0 = row_start_s1 ? '0 : pend0_q;
		err_in.pend1 = row_start_s1 ? '0 : pend1_q;
		if (first_row_s1)
			err_in.above = '0;
		else if (byp_hit_s1)
			err_in.above = byp_data_s1;
		else
			err_in.above = bank_rdata[rd_bank_s1];
	end

	fsd_pixel u_pixel (
		.fmt           (out_fmt_q),
		.swap_red_blue (swap_red_blue_q),
		.pix           (pix_s1),
		.err_in        (err_in),
		.pixel_word    (word),
		.upd           (upd)
	);

	// error line writes of the item leaving stage 1; tail entries only at row end
	always_comb begin
		wr_ent[0] = fsd_pkg::ENT_W'(col_s1);
		wr_ent[1] = fsd_pkg::ENT_W'(col_s1) + fsd_pkg::ENT_W'(1);
		wr_ent[2] = fsd_pkg::ENT_W'(col_s1) + fsd_pkg::ENT_W'(2);
		wr_en[0]  = adv;
		wr_en[1]  = adv & row_end_s1;
		wr_en[2]  = adv & row_end_s1;
		wr_data[0] = upd.below;
		for (int ch = 0; ch < fsd_pkg::NUM_CH; ch++) begin
			wr_data[1][ch] = fsd_pkg::ERR_W'(upd.pend0[ch]);
			wr_data[2][ch] = fsd_pkg::ERR_W'(upd.pend1[ch]);
		end
	end

	// read of the incoming item colliding with a write at the same edge
	always_comb begin
		byp_hit  = 1'b0;
		byp_data = '0;
		for (int j = 0; j < fsd_pkg::NUM_WR; j++) begin
			if (wr_en[j] && wr_ent[j] == rd_ent) begin
				byp_hit  = 1'b1;
				byp_data = wr_data[j];
			end
		end
	end

	always_comb begin
		for (int b = 0; b < fsd_pkg::NUM_BANKS; b++) begin
			bank_we[b]    = 1'b0;
			bank_waddr[b] = clr_idx_q;
			bank_wdata[b] = '0;
			if (clr_active_q) begin
				bank_we[b] = 1'b1;
			end else begin
				for (int j = 0; j < fsd_pkg::NUM_WR; j++) begin
					if (wr_en[j] && fsd_pkg::bank_sel(wr_ent[j]) == fsd_pkg::BANK_SEL_W'(b)) begin
						bank_we[b]    = 1'b1;
						bank_waddr[b] = fsd_pkg::bank_row(wr_ent[j]);
						bank_wdata[b] = wr_data[j];
					end
				end
			end
		end
	end

	for (genvar g = 0; g < fsd_pkg::NUM_BANKS; g++) begin : g_bank
		fsd_ram #(
			.WIDTH (fsd_pkg::ENTRY_BITS),
			.DEPTH (fsd_pkg::BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[g]),
			.waddr (bank_waddr[g]),
			.wdata (bank_wdata[g]),
			.re    (in_acc),
			.raddr (rd_row),
			.rdata (bank_rdata[g])
		);
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			column_q     <= '0;
			first_row_q  <= 1'b1;
			right_q      <= '0;
			pend0_q      <= '0;
			pend1_q      <= '0;
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;

			if (adv)
				valid_s2 <= 1'b1;
			else if (m_axis_tready)
				valid_s2 <= 1'b0;

			if (in_acc) begin
				column_q    <= row_end_in ? '0 : col_in + fsd_pkg::COL_W'(1);
				first_row_q <= row_end_in ? 1'b0 : fr_in;
			end

			if (adv) begin
				right_q <= upd.right;
				pend0_q <= upd.pend0;
				pend1_q <= upd.pend1;
			end

			if (clr_active_q) begin
				clr_idx_q <= clr_idx_q + fsd_pkg::BANK_AW'(1);
				if (clr_idx_q == CLR_LAST)
					clr_active_q <= 1'b0;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1       <= s_axis_tdata;
			col_s1       <= col_in;
			row_start_s1 <= (col_in == '0);
			first_row_s1 <= fr_in;
			row_end_s1   <= row_end_in;
			rd_bank_s1   <= fsd_pkg::bank_sel(rd_ent);
			byp_hit_s1   <= byp_hit;
			byp_data_s1  <= byp_data;
		end
		if (adv)
			word_s2 <= word;
	end

	// ---------------- assertions ----------------
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !s_axis_tready)
		else $error("input transfer possible during error line clear");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while both stages are stalled");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && row_end_in) |=> (column_q == '0 && !first_row_q))
		else $error("column did not wrap at row end");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(adv))
		else $error("output valid without a stage 1 transfer");

endmodule
